// ===== design/hbs_pkg.sv =====
package hbs_pkg;

  // Default grid limits
  localparam int unsigned MAX_WIDTH_DEF = 256;
  localparam int unsigned MAX_DEPTH_DEF = 256;

  // Field widths
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned EXT_W       = 23;
  localparam int unsigned SCALE_W     = 24;
  localparam int unsigned HGT_W       = 24;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned FRAC_W      = 9;
  localparam int unsigned TOTAL_W     = 2 * SIZE_W;
  localparam int unsigned ADDR_CALC_W = 2 * SIZE_W + 1;
  localparam int unsigned IN_DATA_W   = SAMPLE_W + 2 * COORD_W;

  // Fraction of 1.0 in the 8-bit blend
  localparam logic [FRAC_W-1:0] FRAC_ONE = 9'd256;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_LOADED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ACCEPTED   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 3'd6;

  // Corner select for grid reads
  localparam logic [1:0] CORNER_00 = 2'd0;
  localparam logic [1:0] CORNER_10 = 2'd1;
  localparam logic [1:0] CORNER_01 = 2'd2;
  localparam logic [1:0] CORNER_11 = 2'd3;

  // Active configuration, grid sizes already clamped
  typedef struct packed {
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  depth;
    logic [EXT_W-1:0]   extent_x;
    logic [EXT_W-1:0]   extent_z;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_z;
    logic [SCALE_W-1:0] height_scale;
  } hbs_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       ld_g;
    logic       ld_cell;
    logic       ld_base;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_h00;
    logic       cap_h10;
    logic       cap_h01;
    logic       ld_lx;
    logic       ld_lz;
    logic       ld_prod;
    logic       ld_res_acc;
    logic       ld_res_int;
    logic       move_out;
  } hbs_cmd_t;

endpackage

// ===== design/hbs_cfg.sv =====
module hbs_cfg #(
  parameter int unsigned MAX_WIDTH = hbs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_DEPTH = hbs_pkg::MAX_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  index_i,
  input  logic [hbs_pkg::CFG_DATA_W-1:0] data_i,
  output hbs_pkg::hbs_cfg_t              cfg_o
);

  logic [hbs_pkg::SIZE_W-1:0]  width_q, depth_q;
  logic [hbs_pkg::EXT_W-1:0]   extent_x_q, extent_z_q;
  logic [hbs_pkg::SCALE_W-1:0] scale_x_q, scale_z_q, height_scale_q;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q        <= 9'd256;
      depth_q        <= 9'd256;
      extent_x_q     <= 23'd65536;
      extent_z_q     <= 23'd65536;
      scale_x_q      <= 24'd65280;
      scale_z_q      <= 24'd65280;
      height_scale_q <= 24'd65536;
    end else if (wr_en_i) begin
      case (index_i)
        hbs_pkg::REG_GRID_WIDTH:   width_q        <= data_i[hbs_pkg::SIZE_W-1:0];
        hbs_pkg::REG_GRID_DEPTH:   depth_q        <= data_i[hbs_pkg::SIZE_W-1:0];
        hbs_pkg::REG_EXTENT_X:     extent_x_q     <= data_i[hbs_pkg::EXT_W-1:0];
        hbs_pkg::REG_EXTENT_Z:     extent_z_q     <= data_i[hbs_pkg::EXT_W-1:0];
        hbs_pkg::REG_SCALE_X:      scale_x_q      <= data_i;
        hbs_pkg::REG_SCALE_Z:      scale_z_q      <= data_i;
        hbs_pkg::REG_HEIGHT_SCALE: height_scale_q <= data_i;
        default: ;
      endcase
    end
  end

  // Clamp grid sizes to [2, MAX]
  always_comb begin
    cfg_o = '0;
    if (width_q < 9'd2) begin
      cfg_o.width = 9'd2;
    end else if (32'(width_q) > MAX_WIDTH) begin
      cfg_o.width = hbs_pkg::SIZE_W'(MAX_WIDTH);
    end else begin
      cfg_o.width = width_q;
    end
    if (depth_q < 9'd2) begin
      cfg_o.depth = 9'd2;
    end else if (32'(depth_q) > MAX_DEPTH) begin
      cfg_o.depth = hbs_pkg::SIZE_W'(MAX_DEPTH);
    end else begin
      cfg_o.depth = depth_q;
    end
    cfg_o.extent_x     = extent_x_q;
    cfg_o.extent_z     = extent_z_q;
    cfg_o.scale_x      = scale_x_q;
    cfg_o.scale_z      = scale_z_q;
    cfg_o.height_scale = height_scale_q;
  end

endmodule

// ===== design/hbs_ctrl.sv =====
module hbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  logic              interp_i,
  output hbs_pkg::hbs_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_CELL = 4'd2;
  localparam logic [3:0] S_BASE = 4'd3;
  localparam logic [3:0] S_RD0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_RD3  = 4'd7;
  localparam logic [3:0] S_LX   = 4'd8;
  localparam logic [3:0] S_LZ   = 4'd9;
  localparam logic [3:0] S_PROD = 4'd10;
  localparam logic [3:0] S_RND  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       res_valid_q, res_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, move, res_free, accept;

  // Sequencer and result/output slot control
  always_comb begin
    out_free  = !out_valid_q || m_ready_i;
    move      = res_valid_q && out_free;
    res_free  = !res_valid_q || move;
    s_ready_o = (state_q == S_IDLE) && res_free;
    accept    = s_valid_i && s_ready_o;

    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && interp_i) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.ld_g = 1'b1;
        state_d    = S_CELL;
      end
      S_CELL: begin
        cmd_o.ld_cell = 1'b1;
        state_d       = S_BASE;
      end
      S_BASE: begin
        cmd_o.ld_base = 1'b1;
        state_d       = S_RD0;
      end
      S_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = hbs_pkg::CORNER_00;
        state_d      = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = hbs_pkg::CORNER_10;
        cmd_o.cap_h00 = 1'b1;
        state_d       = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = hbs_pkg::CORNER_01;
        cmd_o.cap_h10 = 1'b1;
        state_d       = S_RD3;
      end
      S_RD3: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = hbs_pkg::CORNER_11;
        cmd_o.cap_h01 = 1'b1;
        state_d       = S_LX;
      end
      S_LX: begin
        cmd_o.ld_lx = 1'b1;
        state_d     = S_LZ;
      end
      S_LZ: begin
        cmd_o.ld_lz = 1'b1;
        state_d     = S_PROD;
      end
      S_PROD: begin
        cmd_o.ld_prod = 1'b1;
        state_d       = S_RND;
      end
      S_RND: begin
        if (res_free) begin
          cmd_o.ld_res_int = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    cmd_o.accept     = accept;
    cmd_o.ld_res_acc = accept && !interp_i;
    cmd_o.move_out   = move;

    if (cmd_o.ld_res_acc || cmd_o.ld_res_int) begin
      res_valid_d = 1'b1;
    end else if (move) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end

    if (move) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// ===== design/hbs_dp.sv =====
module hbs_dp #(
  parameter int unsigned MAX_WIDTH = hbs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_DEPTH = hbs_pkg::MAX_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hbs_pkg::hbs_cfg_t             cfg_i,
  input  hbs_pkg::hbs_cmd_t             cmd_i,
  input  logic [hbs_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [hbs_pkg::IN_DATA_W-1:0] in_data_i,
  output logic                          interp_o,
  output logic [hbs_pkg::STATUS_W-1:0]  status_o,
  output logic [hbs_pkg::HGT_W-1:0]     height_o
);

  localparam int unsigned STORE_N = MAX_WIDTH * MAX_DEPTH;
  localparam int unsigned AW      = $clog2(STORE_N);
  localparam int unsigned PTR_W   = $clog2(STORE_N + 1);
  localparam int unsigned CW      = hbs_pkg::ADDR_CALC_W;
  localparam int unsigned GW      = hbs_pkg::EXT_W + hbs_pkg::SCALE_W;

  // Input fields
  logic [hbs_pkg::SAMPLE_W-1:0] sample;
  logic [hbs_pkg::COORD_W-1:0]  coord_x, coord_z;

  logic [PTR_W-1:0]             ptr_q, ptr_d;
  logic [hbs_pkg::TOTAL_W-1:0]  total;
  logic                         not_full, outside, wr_en;
  logic [hbs_pkg::STATUS_W-1:0] acc_status;

  logic [hbs_pkg::EXT_W-1:0]    x_q, z_q;
  logic [GW-1:0]                gx_q, gz_q;
  logic [hbs_pkg::SIZE_W-1:0]   lim_x, lim_z, cx_d, cz_d, cx_q, cz_q;
  logic [hbs_pkg::FRAC_W-1:0]   fx_d, fz_d, fx_q, fz_q;
  logic                         clamp_x, clamp_z;
  logic [CW-1:0]                base_d, base_q, addr_calc;
  logic [AW-1:0]                rd_addr;

  logic [hbs_pkg::SAMPLE_W-1:0] height_mem_q [STORE_N];
  logic [hbs_pkg::SAMPLE_W-1:0] rd_q, h00_q, h10_q, h01_q;

  logic [24:0]                  top_full, bot_full;
  logic [23:0]                  top_q, bot_q;
  logic [32:0]                  v_full;
  logic [31:0]                  v_q;
  logic [55:0]                  prod_q, rnd;

  logic [hbs_pkg::STATUS_W-1:0] res_status_q, out_status_q;
  logic [hbs_pkg::HGT_W-1:0]    res_height_q, out_height_q;

  assign sample  = in_data_i[15:0];
  assign coord_x = in_data_i[39:16];
  assign coord_z = in_data_i[63:40];

  // Load state and early status of an incoming transaction
  always_comb begin
    total    = {{hbs_pkg::SIZE_W{1'b0}}, cfg_i.width} * {{hbs_pkg::SIZE_W{1'b0}}, cfg_i.depth};
    not_full = 32'(ptr_q) < 32'(total);
    outside  = coord_x[23] || (coord_x[22:0] > cfg_i.extent_x) ||
               coord_z[23] || (coord_z[22:0] > cfg_i.extent_z);
    case (in_cmd_i)
      hbs_pkg::CMD_RESTART: acc_status = hbs_pkg::STAT_ACCEPTED;
      hbs_pkg::CMD_WRITE: begin
        acc_status = not_full ? hbs_pkg::STAT_ACCEPTED : hbs_pkg::STAT_OVERFLOW;
      end
      hbs_pkg::CMD_QUERY: begin
        if (not_full) begin
          acc_status = hbs_pkg::STAT_NOT_LOADED;
        end else if (outside) begin
          acc_status = hbs_pkg::STAT_OUTSIDE;
        end else begin
          acc_status = hbs_pkg::STAT_OK;
        end
      end
      default: acc_status = hbs_pkg::STAT_OVERFLOW;
    endcase
    interp_o = (in_cmd_i == hbs_pkg::CMD_QUERY) && !not_full && !outside;
    wr_en    = cmd_i.accept && (in_cmd_i == hbs_pkg::CMD_WRITE) && not_full;
    ptr_d    = ptr_q;
    if (cmd_i.accept && (in_cmd_i == hbs_pkg::CMD_RESTART)) begin
      ptr_d = '0;
    end else if (wr_en) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // Cell index clamp and fraction; a clamped cell saturates the fraction to 1.0
  always_comb begin
    lim_x   = cfg_i.width - 9'd2;
    lim_z   = cfg_i.depth - 9'd2;
    clamp_x = gx_q[GW-1:24] > {14'd0, lim_x};
    clamp_z = gz_q[GW-1:24] > {14'd0, lim_z};
    cx_d    = clamp_x ? lim_x : gx_q[32:24];
    cz_d    = clamp_z ? lim_z : gz_q[32:24];
    fx_d    = clamp_x ? hbs_pkg::FRAC_ONE : {1'b0, gx_q[23:16]};
    fz_d    = clamp_z ? hbs_pkg::FRAC_ONE : {1'b0, gz_q[23:16]};
    base_d  = CW'(cz_q) * CW'(cfg_i.width) + CW'(cx_q);
  end

  // Corner address select
  always_comb begin
    case (cmd_i.rd_sel)
      hbs_pkg::CORNER_00: addr_calc = base_q;
      hbs_pkg::CORNER_10: addr_calc = base_q + 1'b1;
      hbs_pkg::CORNER_01: addr_calc = base_q + CW'(cfg_i.width);
      hbs_pkg::CORNER_11: addr_calc = base_q + CW'(cfg_i.width) + 1'b1;
      default:            addr_calc = base_q;
    endcase
    rd_addr = AW'(addr_calc);
  end

  // Bilinear blend, x then z
  always_comb begin
    top_full = 25'(h00_q) * 25'(hbs_pkg::FRAC_ONE - fx_q) + 25'(h10_q) * 25'(fx_q);
    bot_full = 25'(h01_q) * 25'(hbs_pkg::FRAC_ONE - fx_q) + 25'(rd_q) * 25'(fx_q);
    v_full   = 33'(top_q) * 33'(hbs_pkg::FRAC_ONE - fz_q) + 33'(bot_q) * 33'(fz_q);
    rnd      = prod_q + 56'h0000_0080_0000_00;
  end

  // Grid memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) height_mem_q[ptr_q[AW-1:0]] <= sample;
    if (cmd_i.rd_en) rd_q <= height_mem_q[rd_addr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= coord_x[22:0];
      z_q <= coord_z[22:0];
    end
    if (cmd_i.ld_g) begin
      gx_q <= x_q * cfg_i.scale_x;
      gz_q <= z_q * cfg_i.scale_z;
    end
    if (cmd_i.ld_cell) begin
      cx_q <= cx_d;
      cz_q <= cz_d;
      fx_q <= fx_d;
      fz_q <= fz_d;
    end
    if (cmd_i.ld_base) base_q <= base_d;
    if (cmd_i.cap_h00) h00_q <= rd_q;
    if (cmd_i.cap_h10) h10_q <= rd_q;
    if (cmd_i.cap_h01) h01_q <= rd_q;
    if (cmd_i.ld_lx) begin
      top_q <= top_full[23:0];
      bot_q <= bot_full[23:0];
    end
    if (cmd_i.ld_lz) v_q <= v_full[31:0];
    if (cmd_i.ld_prod) prod_q <= v_q * cfg_i.height_scale;
    if (cmd_i.ld_res_acc) begin
      res_status_q <= acc_status;
      res_height_q <= '0;
    end else if (cmd_i.ld_res_int) begin
      res_status_q <= hbs_pkg::STAT_OK;
      res_height_q <= rnd[55:32];
    end
    if (cmd_i.move_out) begin
      out_status_q <= res_status_q;
      out_height_q <= res_height_q;
    end
  end

  assign status_o = out_status_q;
  assign height_o = out_height_q;

endmodule

// ===== design/heightfield_bilinear_sampler_top.sv =====
// Heightfield bilinear sampler.
// Slave stream: tuser carries the command (restart load, write sample, query),
// tdata carries sample_value, coord_x and coord_z. Master stream: tuser carries
// the status, tdata the Q24.0 height. Every input transaction yields exactly
// one output transaction, in order.
// Load the grid with a restart followed by width*depth writes in raster order.
// Restart, write and rejected queries can stream back to back while the
// output drains; m_axis_tvalid rises when a result moves from the result
// slot into the output register. An interpolated query occupies the block
// through address math, then four corner reads serialized on the single grid
// memory read port, then the blend, height-scale multiply and rounding.
// Results pass through a result slot and an output register, so one more
// transaction is accepted while a finished result waits on m_axis_tready;
// after that the input stalls until the receiver drains.
// Reset clears the write pointer, the handshake state and restores the
// configuration defaults; grid contents are not cleared. Configuration writes
// are always ready and not gated; the user must issue them only while idle.
module heightfield_bilinear_sampler_top #(
  parameter int unsigned MAX_WIDTH = hbs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_DEPTH = hbs_pkg::MAX_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // sample_value, coord_x, coord_z
  input  logic [1:0]                     s_axis_tuser,  // command
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // height
  output logic [2:0]                     m_axis_tuser   // status
);

  hbs_pkg::hbs_cfg_t cfg;
  hbs_pkg::hbs_cmd_t cmd;
  logic              interp;

  assign cfg_ready_o = 1'b1;

  hbs_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  hbs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .interp_i  (interp),
    .cmd_o     (cmd)
  );

  hbs_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .in_cmd_i  (s_axis_tuser),
    .in_data_i (s_axis_tdata),
    .interp_o  (interp),
    .status_o  (m_axis_tuser),
    .height_o  (m_axis_tdata)
  );

  // Assertions

  // Checks that an interpolated query lands its result at the end of its sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && interp) |-> ##11 cmd.ld_res_int)
    else $error("interpolated result not produced on schedule");

  // Checks that the corner-00 read is directly followed by the corner-10 read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_en && (cmd.rd_sel == hbs_pkg::CORNER_00)) |=>
    (cmd.rd_en && (cmd.rd_sel == hbs_pkg::CORNER_10)))
    else $error("corner read burst broken");

  // Height is zero on every non-height status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != hbs_pkg::STAT_OK)) |-> (m_axis_tdata == '0))
    else $error("nonzero height with non-height status");

endmodule
